/* sv/typed_slab_handle_allocator_assert.svh */
// assertion macros for the typed slab handle allocator
`ifndef TYPED_SLAB_HANDLE_ALLOCATOR_ASSERT_SVH
`define TYPED_SLAB_HANDLE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TSHA_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define TSHA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define TSHA_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define TSHA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* sv/tsha_pkg.sv */
// shared constants and record types of the typed slab handle allocator
package tsha_pkg;
    localparam int SLOTS_PER_BUCKET = 64;
    localparam int MAX_BUCKETS      = 256;
    localparam int NUM_TYPES        = 10;

    localparam int SLOT_W  = $clog2(SLOTS_PER_BUCKET);
    localparam int BKT_W   = $clog2(MAX_BUCKETS);
    localparam int CNT_W   = $clog2(MAX_BUCKETS + 1);
    localparam int TYPE_W  = 4;
    localparam int LIN_W   = SLOT_W + BKT_W;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_NO_BKT   = 2'd2;
    localparam logic [1:0] ST_BAD_HDL  = 2'd3;

    typedef struct packed {
        logic              live;
        logic [TYPE_W-1:0] btype;
        logic [SLOT_W-1:0] free_head;
        logic              has_free;
        logic [BKT_W-1:0]  next_partial;
        logic              np_valid;
    } bucket_rec_t;

    typedef struct packed {
        logic [SLOT_W-1:0] next_free;
        logic              is_last;
        logic              used;
    } slot_rec_t;
endpackage

/* sv/tsha_ram.sv */
// generic simple dual-port ram with registered read
module tsha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/typed_slab_handle_allocator.sv */
// Typed slab handle allocator. One item is taken at a time; s_ready is high
// only while the sequencer is idle, and a finished result sits in the output
// register so the next item can be taken while it waits. An allocate from a
// type with a partial bucket passes through decode, bucket read, slot read
// and write-back; a free through decode, read and check; an unknown kind or
// a rejected item goes from decode straight to finish. Opening a new bucket
// first writes the slot memory once per slot. A clear visits each opened
// bucket with a read-modify-write of the bucket memory. A stalled result
// receiver holds the sequencer in its finish state until the output register
// frees up. State lives in a 256-entry bucket memory and a 16384-entry slot
// memory; no clearing pass is needed since only entries below the
// opened-bucket count are ever read.
module typed_slab_handle_allocator
    import tsha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [9:0]  s_type_mask,
    input  logic [14:0] s_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_handle_out,
    output logic [1:0]  m_status
);
`include "typed_slab_handle_allocator_assert.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_OPEN   = 4'd2;
    localparam logic [3:0] S_A_RB   = 4'd3;
    localparam logic [3:0] S_A_RS   = 4'd4;
    localparam logic [3:0] S_A_WR   = 4'd5;
    localparam logic [3:0] S_F_RD   = 4'd6;
    localparam logic [3:0] S_F_CHK  = 4'd7;
    localparam logic [3:0] S_C_RD   = 4'd8;
    localparam logic [3:0] S_C_WR   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_BUCKET - 1);

    logic [3:0]        state_reg, state_next;
    logic [1:0]        kind_reg;
    logic [9:0]        mask_reg;
    logic [14:0]       hdl_reg;
    logic [TYPE_W-1:0] tsel_reg, tsel_next;
    logic [BKT_W-1:0]  bkt_reg, bkt_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  opened_reg, opened_next;
    bucket_rec_t       brec_reg, brec_next;
    logic [14:0]       res_hdl_reg, res_hdl_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic [BKT_W-1:0]  thead_reg [NUM_TYPES];
    logic [BKT_W-1:0]  thead_next [NUM_TYPES];
    logic [NUM_TYPES-1:0] tvalid_reg, tvalid_next;
    logic              m_valid_reg;
    logic [14:0]       m_hdl_reg;
    logic [1:0]        m_st_reg;

    // memory ports
    logic              b_we, s_we;
    logic [BKT_W-1:0]  b_waddr, b_raddr;
    logic [LIN_W-1:0]  s_waddr, s_raddr;
    bucket_rec_t       b_wdata, b_rdata;
    slot_rec_t         s_wdata, s_rdata;

    tsha_ram #(.WIDTH($bits(bucket_rec_t)), .DEPTH(MAX_BUCKETS)) u_bucket_ram (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    tsha_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(MAX_BUCKETS * SLOTS_PER_BUCKET)) u_slot_ram (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    // decode of the latched item
    logic              mask_onehot;
    logic [TYPE_W-1:0] mask_idx;
    logic [14:0]       lin;
    logic [15:0]       mask_wide;

    always_comb begin
        mask_onehot = (mask_reg != 10'd0) && ((mask_reg & (mask_reg - 10'd1)) == 10'd0);
        mask_idx    = '0;
        for (int i = 0; i < 10; i++) begin
            if (mask_reg[i]) begin
                mask_idx = TYPE_W'(i);
            end
        end
        lin       = hdl_reg - 15'd1;
        mask_wide = {6'd0, mask_reg};
    end

    assign s_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        tsel_next    = tsel_reg;
        bkt_next     = bkt_reg;
        cnt_next     = cnt_reg;
        opened_next  = opened_reg;
        brec_next    = brec_reg;
        res_hdl_next = res_hdl_reg;
        res_st_next  = res_st_reg;
        thead_next   = thead_reg;
        tvalid_next  = tvalid_reg;
        b_we    = 1'b0;
        b_waddr = bkt_reg;
        b_wdata = brec_reg;
        b_raddr = bkt_reg;
        s_we    = 1'b0;
        s_waddr = {bkt_reg, cnt_reg[SLOT_W-1:0]};
        s_wdata = '0;
        s_raddr = lin[LIN_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next   = S_DEC;
                    res_hdl_next = '0;
                    res_st_next  = ST_OK;
                end
            end
            S_DEC: begin
                case (kind_reg)
                    KIND_ALLOC: begin
                        tsel_next = mask_idx;
                        if (!mask_onehot || (32'(mask_idx) >= NUM_TYPES)) begin
                            res_st_next = ST_BAD_TYPE;
                            state_next  = S_FIN;
                        end else if (tvalid_reg[mask_idx]) begin
                            bkt_next   = thead_reg[mask_idx];
                            state_next = S_A_RB;
                        end else if (32'(opened_reg) >= MAX_BUCKETS) begin
                            res_st_next = ST_NO_BKT;
                            state_next  = S_FIN;
                        end else begin
                            bkt_next   = opened_reg[BKT_W-1:0];
                            cnt_next   = '0;
                            state_next = S_OPEN;
                        end
                    end
                    KIND_FREE: begin
                        if ((hdl_reg == 15'd0) ||
                            (32'(lin[14:SLOT_W]) >= 32'(opened_reg))) begin
                            res_st_next = ST_BAD_HDL;
                            state_next  = S_FIN;
                        end else begin
                            bkt_next   = lin[LIN_W-1:SLOT_W];
                            state_next = S_F_RD;
                        end
                    end
                    KIND_CLEAR: begin
                        tvalid_next = tvalid_reg & ~mask_reg[NUM_TYPES-1:0];
                        cnt_next    = '0;
                        state_next  = (opened_reg == '0) ? S_FIN : S_C_RD;
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            // build the fresh bucket's free list, one slot a cycle
            S_OPEN: begin
                s_we    = 1'b1;
                s_waddr = {bkt_reg, cnt_reg[SLOT_W-1:0]};
                s_wdata.next_free = cnt_reg[SLOT_W-1:0] + SLOT_W'(1);
                s_wdata.is_last   = (cnt_reg[SLOT_W-1:0] == LAST_SLOT);
                s_wdata.used      = 1'b0;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[SLOT_W-1:0] == LAST_SLOT) begin
                    b_we    = 1'b1;
                    b_waddr = bkt_reg;
                    b_wdata.live         = 1'b1;
                    b_wdata.btype        = tsel_reg;
                    b_wdata.free_head    = '0;
                    b_wdata.has_free     = 1'b1;
                    b_wdata.next_partial = '0;
                    b_wdata.np_valid     = 1'b0;
                    thead_next[tsel_reg]  = bkt_reg;
                    tvalid_next[tsel_reg] = 1'b1;
                    opened_next = opened_reg + CNT_W'(1);
                    state_next  = S_A_RB;
                end
            end
            S_A_RB: begin
                b_raddr    = bkt_reg;
                state_next = S_A_RS;
            end
            S_A_RS: begin
                brec_next  = b_rdata;
                s_raddr    = {bkt_reg, b_rdata.free_head};
                state_next = S_A_WR;
            end
            // take the head slot and unlink the bucket once it runs dry
            S_A_WR: begin
                s_we    = 1'b1;
                s_waddr = {bkt_reg, brec_reg.free_head};
                s_wdata = s_rdata;
                s_wdata.used = 1'b1;
                b_we    = 1'b1;
                b_waddr = bkt_reg;
                b_wdata = brec_reg;
                if (s_rdata.is_last) begin
                    b_wdata.has_free      = 1'b0;
                    b_wdata.np_valid      = 1'b0;
                    thead_next[tsel_reg]  = brec_reg.next_partial;
                    tvalid_next[tsel_reg] = brec_reg.np_valid;
                end else begin
                    b_wdata.free_head = s_rdata.next_free;
                end
                res_hdl_next = 15'({bkt_reg, brec_reg.free_head}) + 15'd1;
                state_next   = S_FIN;
            end
            S_F_RD: begin
                b_raddr    = bkt_reg;
                s_raddr    = lin[LIN_W-1:0];
                state_next = S_F_CHK;
            end
            // push the slot back and relink a bucket that was full
            S_F_CHK: begin
                state_next = S_FIN;
                if (!b_rdata.live || !s_rdata.used || (32'(b_rdata.btype) >= NUM_TYPES)) begin
                    res_st_next = ST_BAD_HDL;
                end else begin
                    b_we    = 1'b1;
                    b_waddr = bkt_reg;
                    b_wdata = b_rdata;
                    if (!b_rdata.has_free) begin
                        b_wdata.next_partial = thead_reg[b_rdata.btype];
                        b_wdata.np_valid     = tvalid_reg[b_rdata.btype];
                        thead_next[b_rdata.btype]  = bkt_reg;
                        tvalid_next[b_rdata.btype] = 1'b1;
                    end
                    b_wdata.free_head = lin[SLOT_W-1:0];
                    b_wdata.has_free  = 1'b1;
                    s_we    = 1'b1;
                    s_waddr = lin[LIN_W-1:0];
                    s_wdata.next_free = b_rdata.free_head;
                    s_wdata.is_last   = !b_rdata.has_free;
                    s_wdata.used      = 1'b0;
                end
            end
            S_C_RD: begin
                b_raddr    = cnt_reg[BKT_W-1:0];
                state_next = S_C_WR;
            end
            // drop a live bucket whose type is in the mask
            S_C_WR: begin
                b_waddr = cnt_reg[BKT_W-1:0];
                b_wdata = b_rdata;
                b_wdata.live = 1'b0;
                b_we = b_rdata.live && mask_wide[b_rdata.btype];
                cnt_next = cnt_reg + CNT_W'(1);
                state_next = (cnt_reg + CNT_W'(1) == opened_reg) ? S_FIN : S_C_RD;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            opened_reg  <= '0;
            tvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            opened_reg <= opened_next;
            tvalid_reg <= tvalid_next;
            if ((state_reg == S_FIN) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            mask_reg <= s_type_mask;
            hdl_reg  <= s_handle;
        end
        tsel_reg    <= tsel_next;
        bkt_reg     <= bkt_next;
        cnt_reg     <= cnt_next;
        brec_reg    <= brec_next;
        res_hdl_reg <= res_hdl_next;
        res_st_reg  <= res_st_next;
        thead_reg   <= thead_next;
        if ((state_reg == S_FIN) && (!m_valid_reg || m_ready)) begin
            m_hdl_reg <= res_hdl_reg;
            m_st_reg  <= res_st_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_handle_out = m_hdl_reg;
    assign m_status     = m_st_reg;

    `TSHA_ASSERT_IMPLY(a_opened_bound, aclk, aresetn, 1'b1, 32'(opened_reg) <= MAX_BUCKETS)
    `TSHA_ASSERT_IMPLY(a_fail_zero, aclk, aresetn, m_valid && (m_status != ST_OK), m_handle_out == 15'd0)
    `TSHA_ASSERT_NEXT(a_open_counts, aclk, aresetn, (state_reg == S_OPEN) && (cnt_reg[SLOT_W-1:0] == LAST_SLOT), opened_reg == $past(opened_reg) + CNT_W'(1))
endmodule
